### hw/rtl/sample_accumulate_gamma_resolve_assert.svh
// Assertion macros shared by the accumulation buffer RTL
`ifndef SAMPLE_ACCUMULATE_GAMMA_RESOLVE_ASSERT_SVH
`define SAMPLE_ACCUMULATE_GAMMA_RESOLVE_ASSERT_SVH

// checked outside reset
`define SAGR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define SAGR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### hw/rtl/sagr_pkg.sv
// Types, constants and log table for the accumulation buffer
package sagr_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int PIX_COUNT  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(PIX_COUNT);
  localparam int SUM_W      = 32;
  localparam int SMP_W      = 16;
  localparam int LOG_W      = 21;
  localparam int LUT_W      = 19;
  localparam int QUO_W      = 33;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = 1;
  localparam int QCNT_W     = 2;

  localparam logic [8:0]  WIDTH_RST  = 9'd256;
  localparam logic [8:0]  HEIGHT_RST = 9'd256;
  localparam logic [15:0] SPP_RST    = 16'd1;
  localparam logic [14:0] GAMMA_RST  = 15'd4096;

  typedef enum logic [1:0] {
    CMD_SET     = 2'd0,
    CMD_ADD     = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_RESOLVE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_SPP    = 2'd2,
    REG_GAMMA  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    cmd_e               cmd;
    logic [7:0]         column;
    logic [7:0]         row;
    logic signed [15:0] sample_red;
    logic signed [15:0] sample_green;
    logic signed [15:0] sample_blue;
  } req_t;

  typedef struct packed {
    logic [7:0] byte_red;
    logic [7:0] byte_green;
    logic [7:0] byte_blue;
    logic       status;
  } rsp_t;

  typedef struct packed {
    logic [8:0]  width_in_use;
    logic [8:0]  height_in_use;
    logic [15:0] samples_per_pixel;
    logic [14:0] gamma_value;
  } cfg_t;

  typedef struct packed {
    cmd_e               cmd;
    logic               oob;
    logic [ADDR_W-1:0]  addr;
    logic signed [15:0] smp_r;
    logic signed [15:0] smp_g;
    logic signed [15:0] smp_b;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t head;
  } q_if_t;

  typedef struct packed {
    logic pop;
    logic init_busy;
  } back_ctl_t;

  typedef logic [LUT_W-1:0] log_lut_t [256];

  // log2 in Q16, mantissa refined by repeated squaring
  function automatic logic [LOG_W-1:0] log2_const(input logic [31:0] x);
    logic [63:0] m;
    logic [4:0]  top;
    logic [15:0] frac;
    top  = '0;
    frac = '0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) top = 5'(i);
    end
    m = 64'(x) << (5'd31 - top);
    for (int i = 0; i < 16; i++) begin
      m    = (m * m) >> 31;
      frac = {frac[14:0], 1'b0};
      if (m >= 64'h1_0000_0000) begin
        frac[0] = 1'b1;
        m       = m >> 1;
      end
    end
    return {top, frac};
  endfunction

  function automatic log_lut_t build_lut();
    log_lut_t t;
    t[0] = '0;
    for (int b = 1; b < 256; b++) begin
      t[b] = LUT_W'(log2_const(32'(b)));
    end
    return t;
  endfunction

  localparam log_lut_t        LOG_LUT = build_lut();
  localparam logic [LUT_W-1:0] LOG_255 = LOG_LUT[255];

endpackage

### hw/rtl/sample_accumulate_gamma_resolve.sv
// Per-pixel RGB accumulation buffer with gamma-corrected byte resolve.
// Requests: start_i with req_i is taken when busy_o is low. Commands are
// set, add (saturating), clear-all and resolve of one pixel.
// Each request gives exactly one result: done_o high for one cycle with
// rsp_o; the receiver cannot stall, so results are never held back.
// Status 1 means the coordinate lies outside the configured frame.
// Resolve runs a log2 of the full-scale bound, then per channel up to a
// log2, a restoring divider and an 8-step table search; clear-all zeroes
// every store entry, one per cycle, on the single RAM port.
// Set finishes in the idle state and add goes through a read state; a two-entry
// queue lets requests enter while the back end works.
// Reset: config returns to 256x256, one sample per pixel, gamma 1.0; the
// store is then swept to zero with busy_o held high.
// Config writes (cfg_we_i) take effect at once and belong in idle periods.
module sample_accumulate_gamma_resolve (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  sagr_pkg::req_t  req_i,
  output logic            busy_o,
  output logic            done_o,
  output sagr_pkg::rsp_t  rsp_o,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [15:0]     cfg_wdata_i
);

  sagr_pkg::cfg_t      cfg_q;
  sagr_pkg::q_if_t     q_if;
  sagr_pkg::back_ctl_t ctl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width_in_use      <= sagr_pkg::WIDTH_RST;
      cfg_q.height_in_use     <= sagr_pkg::HEIGHT_RST;
      cfg_q.samples_per_pixel <= sagr_pkg::SPP_RST;
      cfg_q.gamma_value       <= sagr_pkg::GAMMA_RST;
    end else if (cfg_we_i) begin
      unique case (sagr_pkg::reg_idx_e'(cfg_idx_i))
        sagr_pkg::REG_WIDTH:  cfg_q.width_in_use      <= cfg_wdata_i[8:0];
        sagr_pkg::REG_HEIGHT: cfg_q.height_in_use     <= cfg_wdata_i[8:0];
        sagr_pkg::REG_SPP:    cfg_q.samples_per_pixel <= cfg_wdata_i;
        sagr_pkg::REG_GAMMA:  cfg_q.gamma_value       <= cfg_wdata_i[14:0];
        default:              cfg_q <= cfg_q;
      endcase
    end
  end

  sagr_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .start_i (start_i),
    .req_i   (req_i),
    .ctl_i   (ctl),
    .busy_o  (busy_o),
    .q_o     (q_if)
  );

  sagr_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .q_i    (q_if),
    .ctl_o  (ctl),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

endmodule

### hw/rtl/sagr_log2.sv
// Iterative log2 unit: one-bit normalize, then sixteen squaring steps
module sagr_log2 (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [31:0]                x_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [sagr_pkg::LOG_W-1:0] result_o
);

  typedef enum logic [1:0] {L_IDLE, L_NORM, L_SQR} lstate_e;

  lstate_e                   state_q;
  logic [31:0]               m_q;
  logic [4:0]                top_q;
  logic [15:0]               frac_q;
  logic [3:0]                step_q;
  logic                      done_q;
  logic [sagr_pkg::LOG_W-1:0] res_q;

  logic [63:0] prod;
  logic [32:0] sq;
  logic [31:0] m_next;
  logic [15:0] frac_next;

  assign prod      = 64'(m_q) * 64'(m_q);
  assign sq        = prod[63:31];
  assign m_next    = sq[32] ? sq[32:1] : sq[31:0];
  assign frac_next = {frac_q[14:0], sq[32]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      m_q     <= '0;
      top_q   <= '0;
      frac_q  <= '0;
      step_q  <= '0;
      done_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        L_IDLE: begin
          if (start_i) begin
            m_q     <= x_i;
            top_q   <= 5'd31;
            frac_q  <= '0;
            step_q  <= '0;
            state_q <= L_NORM;
          end
        end
        L_NORM: begin
          if (m_q[31]) begin
            state_q <= L_SQR;
          end else begin
            m_q   <= m_q << 1;
            top_q <= top_q - 5'd1;
          end
        end
        L_SQR: begin
          m_q    <= m_next;
          frac_q <= frac_next;
          step_q <= step_q + 4'd1;
          if (step_q == 4'd15) begin
            res_q   <= {top_q, frac_next};
            done_q  <= 1'b1;
            state_q <= L_IDLE;
          end
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

  assign busy_o   = (state_q != L_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

### hw/rtl/sagr_div.sv
// Restoring divider, one quotient bit per cycle
module sagr_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [sagr_pkg::QUO_W-1:0] dividend_i,
  input  logic [14:0]                divisor_i,
  output logic                       done_o,
  output logic [sagr_pkg::QUO_W-1:0] quotient_o
);

  typedef enum logic {D_IDLE, D_RUN} dstate_e;

  dstate_e                    state_q;
  logic [sagr_pkg::QUO_W-1:0] n_q;
  logic [14:0]                rem_q;
  logic [14:0]                dvs_q;
  logic [5:0]                 cnt_q;
  logic                       done_q;

  logic [15:0] trial;
  logic        ge;
  logic [15:0] diff;

  assign trial = {rem_q, n_q[sagr_pkg::QUO_W-1]};
  assign ge    = (trial >= {1'b0, dvs_q});
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      n_q     <= '0;
      rem_q   <= '0;
      dvs_q   <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        D_IDLE: begin
          if (start_i) begin
            n_q     <= dividend_i;
            rem_q   <= '0;
            dvs_q   <= divisor_i;
            cnt_q   <= '0;
            state_q <= D_RUN;
          end
        end
        D_RUN: begin
          rem_q <= ge ? diff[14:0] : trial[14:0];
          n_q   <= {n_q[sagr_pkg::QUO_W-2:0], ge};
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(sagr_pkg::QUO_W - 1)) begin
            done_q  <= 1'b1;
            state_q <= D_IDLE;
          end
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

  assign done_o     = done_q;
  assign quotient_o = n_q;

endmodule

### hw/rtl/sagr_front.sv
// Front end: request intake, frame check and a two-entry queue
`include "sample_accumulate_gamma_resolve_assert.svh"

module sagr_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sagr_pkg::cfg_t       cfg_i,
  input  logic                 start_i,
  input  sagr_pkg::req_t       req_i,
  input  sagr_pkg::back_ctl_t  ctl_i,
  output logic                 busy_o,
  output sagr_pkg::q_if_t      q_o
);

  sagr_pkg::entry_t              ent_q [sagr_pkg::QDEPTH];
  logic [sagr_pkg::QPTR_W-1:0]   wptr_q;
  logic [sagr_pkg::QPTR_W-1:0]   rptr_q;
  logic [sagr_pkg::QCNT_W-1:0]   cnt_q;
  logic [sagr_pkg::QCNT_W-1:0]   cnt_d;
  logic                          full;
  logic                          push;
  sagr_pkg::entry_t              ent_new;

  assign full   = (cnt_q == sagr_pkg::QCNT_W'(sagr_pkg::QDEPTH));
  assign busy_o = full || ctl_i.init_busy;
  assign push   = start_i && !busy_o;

  always_comb begin
    ent_new.cmd   = req_i.cmd;
    // clear ignores coordinates
    ent_new.oob   = (req_i.cmd != sagr_pkg::CMD_CLEAR) &&
                    (({1'b0, req_i.column} >= cfg_i.width_in_use) ||
                     ({1'b0, req_i.row} >= cfg_i.height_in_use));
    ent_new.addr  = {req_i.row, req_i.column};
    ent_new.smp_r = req_i.sample_red;
    ent_new.smp_g = req_i.sample_green;
    ent_new.smp_b = req_i.sample_blue;
  end

  always_comb begin
    unique case ({push, ctl_i.pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push)      wptr_q <= wptr_q + 1'b1;
      if (ctl_i.pop) rptr_q <= rptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) ent_q[wptr_q] <= ent_new;
  end

  assign q_o.valid = (cnt_q != '0);
  assign q_o.head  = ent_q[rptr_q];

  `SAGR_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= sagr_pkg::QCNT_W'(sagr_pkg::QDEPTH), "queue count past depth")
  `SAGR_ASSERT(a_pop_nonempty, ctl_i.pop |-> (cnt_q != '0), "pop from empty queue")
  `SAGR_ASSERT(a_cnt_step, (push && !ctl_i.pop) |=> (cnt_q == $past(cnt_q) + 2'd1), "queue count lost a push")

endmodule

### hw/rtl/sagr_back.sv
// Back end: pixel store, read-modify-write, clear sweep and resolve sequencer
`include "sample_accumulate_gamma_resolve_assert.svh"

module sagr_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sagr_pkg::cfg_t       cfg_i,
  input  sagr_pkg::q_if_t      q_i,
  output sagr_pkg::back_ctl_t  ctl_o,
  output logic                 done_o,
  output sagr_pkg::rsp_t       rsp_o
);

  localparam int AW = sagr_pkg::ADDR_W;
  localparam int MW = 3 * sagr_pkg::SUM_W;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_READ, ST_CLEAR, ST_LQ, ST_CHAN, ST_LS, ST_DIV, ST_SEARCH, ST_NEXT
  } state_e;

  state_e                         state_q, state_d;
  logic [AW-1:0]                  sweep_q, sweep_d;
  sagr_pkg::entry_t               cur_q, cur_d;
  logic signed [31:0]             sum_q [3];
  logic signed [31:0]             sum_d [3];
  logic [1:0]                     ch_q, ch_d;
  logic [sagr_pkg::LOG_W-1:0]     lq_q, lq_d;
  logic [sagr_pkg::LUT_W-1:0]     t_q, t_d;
  logic [7:0]                     bsel_q, bsel_d;
  logic [2:0]                     bit_q, bit_d;
  logic [7:0]                     byte_q [3];
  logic [7:0]                     byte_d [3];
  logic                           done_q, done_d;
  sagr_pkg::rsp_t                 rsp_q, rsp_d;

  logic [MW-1:0]                  mem_q [sagr_pkg::PIX_COUNT];
  logic [MW-1:0]                  rdata_q;
  logic                           mem_we, mem_re;
  logic [AW-1:0]                  mem_addr;
  logic [MW-1:0]                  mem_wdata;

  logic                           pop;
  logic                           log_start, log_busy, log_done;
  logic [31:0]                    log_x;
  logic [sagr_pkg::LOG_W-1:0]     log_res;
  logic                           div_start, div_done;
  logic [sagr_pkg::QUO_W-1:0]     div_n, div_q;

  logic [15:0]                    spp_eff;
  logic [14:0]                    g_eff;
  logic [31:0]                    q_val;
  logic signed [31:0]             cur_s;
  logic signed [31:0]             rd_r, rd_g, rd_b;
  logic [sagr_pkg::LOG_W-1:0]     dlog;
  logic [7:0]                     cand;
  logic [7:0]                     bnext;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    return s[31:0];
  endfunction

  function automatic logic [31:0] sx(input logic signed [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  assign spp_eff = (cfg_i.samples_per_pixel == '0) ? 16'd1 : cfg_i.samples_per_pixel;
  assign g_eff   = (cfg_i.gamma_value == '0) ? 15'd1 : cfg_i.gamma_value;
  assign q_val   = {4'b0, spp_eff, 12'b0};
  assign cur_s   = sum_q[ch_q];
  assign rd_r    = rdata_q[31:0];
  assign rd_g    = rdata_q[63:32];
  assign rd_b    = rdata_q[95:64];
  assign dlog    = lq_q - log_res;
  assign div_n   = {dlog, 12'b0};
  assign cand    = bsel_q | (8'd1 << bit_q);
  assign bnext   = (sagr_pkg::LOG_LUT[cand] <= t_q) ? cand : bsel_q;

  always_comb begin
    state_d   = state_q;
    sweep_d   = sweep_q;
    cur_d     = cur_q;
    sum_d     = sum_q;
    ch_d      = ch_q;
    lq_d      = lq_q;
    t_d       = t_q;
    bsel_d    = bsel_q;
    bit_d     = bit_q;
    byte_d    = byte_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = cur_q.addr;
    mem_wdata = '0;
    pop       = 1'b0;
    log_start = 1'b0;
    log_x     = q_val;
    div_start = 1'b0;

    unique case (state_q)
      ST_INIT, ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = sweep_q;
        sweep_d  = sweep_q + 1'b1;
        if (sweep_q == '1) begin
          state_d = ST_IDLE;
          if (state_q == ST_CLEAR) begin
            rsp_d  = '0;
            done_d = 1'b1;
          end
        end
      end
      ST_IDLE: begin
        if (q_i.valid) begin
          pop      = 1'b1;
          cur_d    = q_i.head;
          mem_addr = q_i.head.addr;
          if (q_i.head.oob) begin
            rsp_d        = '0;
            rsp_d.status = 1'b1;
            done_d       = 1'b1;
          end else begin
            unique case (q_i.head.cmd)
              sagr_pkg::CMD_CLEAR: begin
                sweep_d = '0;
                state_d = ST_CLEAR;
              end
              sagr_pkg::CMD_SET: begin
                mem_we    = 1'b1;
                mem_wdata = {sx(q_i.head.smp_b), sx(q_i.head.smp_g), sx(q_i.head.smp_r)};
                rsp_d     = '0;
                done_d    = 1'b1;
              end
              sagr_pkg::CMD_ADD, sagr_pkg::CMD_RESOLVE: begin
                mem_re  = 1'b1;
                state_d = ST_READ;
              end
              default: state_d = ST_IDLE;
            endcase
          end
        end
      end
      ST_READ: begin
        if (cur_q.cmd == sagr_pkg::CMD_ADD) begin
          mem_we    = 1'b1;
          mem_wdata = {sat_add(rd_b, sx(cur_q.smp_b)), sat_add(rd_g, sx(cur_q.smp_g)),
                       sat_add(rd_r, sx(cur_q.smp_r))};
          rsp_d     = '0;
          done_d    = 1'b1;
          state_d   = ST_IDLE;
        end else begin
          sum_d[0]  = rd_r;
          sum_d[1]  = rd_g;
          sum_d[2]  = rd_b;
          log_start = 1'b1;
          state_d   = ST_LQ;
        end
      end
      ST_LQ: begin
        if (log_done) begin
          lq_d    = log_res;
          ch_d    = '0;
          state_d = ST_CHAN;
        end
      end
      ST_CHAN: begin
        if (cur_s <= 0) begin
          byte_d[ch_q] = 8'd0;
          state_d      = ST_NEXT;
        end else if (unsigned'(cur_s) >= q_val) begin
          byte_d[ch_q] = 8'd255;
          state_d      = ST_NEXT;
        end else begin
          log_x     = unsigned'(cur_s);
          log_start = 1'b1;
          state_d   = ST_LS;
        end
      end
      ST_LS: begin
        if (log_done) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (div_q > sagr_pkg::QUO_W'(sagr_pkg::LOG_255)) begin
            byte_d[ch_q] = 8'd0;
            state_d      = ST_NEXT;
          end else begin
            // largest code whose log stays at or below this bound
            t_d     = sagr_pkg::LOG_255 - div_q[sagr_pkg::LUT_W-1:0];
            bsel_d  = '0;
            bit_d   = 3'd7;
            state_d = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        bsel_d = bnext;
        bit_d  = bit_q - 3'd1;
        if (bit_q == '0) begin
          byte_d[ch_q] = bnext;
          state_d      = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (ch_q == 2'd2) begin
          rsp_d.byte_red   = byte_q[0];
          rsp_d.byte_green = byte_q[1];
          rsp_d.byte_blue  = byte_q[2];
          rsp_d.status     = 1'b0;
          done_d           = 1'b1;
          state_d          = ST_IDLE;
        end else begin
          ch_d    = ch_q + 2'd1;
          state_d = ST_CHAN;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      sweep_q <= '0;
      done_q  <= 1'b0;
      rsp_q   <= '0;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
      done_q  <= done_d;
      rsp_q   <= rsp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    sum_q  <= sum_d;
    ch_q   <= ch_d;
    lq_q   <= lq_d;
    t_q    <= t_d;
    bsel_q <= bsel_d;
    bit_q  <= bit_d;
    byte_q <= byte_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_addr] <= mem_wdata;
    if (mem_re) rdata_q <= mem_q[mem_addr];
  end

  sagr_log2 u_log (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (log_start),
    .x_i      (log_x),
    .busy_o   (log_busy),
    .done_o   (log_done),
    .result_o (log_res)
  );

  sagr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_n),
    .divisor_i  (g_eff),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  assign ctl_o.pop       = pop;
  assign ctl_o.init_busy = (state_q == ST_INIT);
  assign done_o          = done_q;
  assign rsp_o           = rsp_q;

  `SAGR_ASSERT(a_oob_zero, (done_q && rsp_q.status) |-> (rsp_q.byte_red == '0 && rsp_q.byte_green == '0 && rsp_q.byte_blue == '0), "out of frame result with nonzero bytes")
  `SAGR_ASSERT(a_init_quiet, (state_q == ST_INIT) |-> (!done_q && !pop), "activity during init sweep")
  `SAGR_ASSERT(a_log_free, log_start |-> !log_busy, "log unit started while busy")

endmodule

### dv/tb.sv
// Self-checking testbench for the pixel accumulation buffer with gamma resolve
module tb;
  import sagr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3000000;

  class frame_scoreboard;
    int unsigned width_cfg, height_cfg, spp_cfg, gamma_cfg;
    int red_sum[int], green_sum[int], blue_sum[int];
    rsp_t pending_bytes[$];
    int unsigned log_tab[256];
    int errors;

    function new();
      width_cfg  = 256;
      height_cfg = 256;
      spp_cfg    = 1;
      gamma_cfg  = 4096;
      errors     = 0;
      for (int b = 1; b < 256; b++) log_tab[b] = log2_fix(b);
    endfunction

    // log2 in Q16: top bit index plus fraction by repeated squaring
    function int unsigned log2_fix(int unsigned x);
      int unsigned top;
      int unsigned frac;
      longint unsigned m;
      top  = 0;
      frac = 0;
      for (int i = 0; i < 32; i++) if (x[i]) top = i;
      m = longint'(x) << (31 - top);
      for (int i = 0; i < 16; i++) begin
        m = (m * m) >> 31;
        frac = frac << 1;
        if (m >= 64'h1_0000_0000) begin
          frac = frac | 1;
          m = m >> 1;
        end
      end
      return (top << 16) | frac;
    endfunction

    function logic [7:0] gamma_byte(int s);
      int unsigned spp, g, q, d;
      longint unsigned e;
      spp = (spp_cfg == 0) ? 1 : spp_cfg;
      g   = (gamma_cfg == 0) ? 1 : gamma_cfg;
      q   = spp * 4096;
      if (s <= 0) return 8'd0;
      if (unsigned'(s) >= q) return 8'd255;
      d = log2_fix(q) - log2_fix(unsigned'(s));
      e = (longint'(d) * 4096) / g;
      for (int b = 255; b >= 1; b--)
        if (longint'(log_tab[255] - log_tab[b]) >= e) return b[7:0];
      return 8'd0;
    endfunction

    function int sat_sum(int a, int b);
      longint s;
      s = longint'(a) + longint'(b);
      if (s > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (s < -64'sh8000_0000) return 32'sh8000_0000;
      return int'(s);
    endfunction

    function void write_reg(reg_idx_e idx, logic [15:0] data);
      case (idx)
        REG_WIDTH:  width_cfg  = 32'(data[8:0]);
        REG_HEIGHT: height_cfg = 32'(data[8:0]);
        REG_SPP:    spp_cfg    = 32'(data);
        REG_GAMMA:  gamma_cfg  = 32'(data[14:0]);
      endcase
    endfunction

    function void note_request(req_t r);
      rsp_t x;
      int unsigned wl, hl;
      int k, rs, gs, bs;
      x  = '0;
      wl = (width_cfg < MAX_WIDTH) ? width_cfg : MAX_WIDTH;
      hl = (height_cfg < MAX_HEIGHT) ? height_cfg : MAX_HEIGHT;
      k  = r.row * MAX_WIDTH + r.column;
      if (r.cmd == CMD_CLEAR) begin
        red_sum.delete();
        green_sum.delete();
        blue_sum.delete();
      end else if (r.column >= wl || r.row >= hl) begin
        x.status = 1'b1;
      end else begin
        rs = red_sum.exists(k) ? red_sum[k] : 0;
        gs = green_sum.exists(k) ? green_sum[k] : 0;
        bs = blue_sum.exists(k) ? blue_sum[k] : 0;
        case (r.cmd)
          CMD_SET: begin
            red_sum[k]   = int'(r.sample_red);
            green_sum[k] = int'(r.sample_green);
            blue_sum[k]  = int'(r.sample_blue);
          end
          CMD_ADD: begin
            red_sum[k]   = sat_sum(rs, int'(r.sample_red));
            green_sum[k] = sat_sum(gs, int'(r.sample_green));
            blue_sum[k]  = sat_sum(bs, int'(r.sample_blue));
          end
          default: begin
            x.byte_red   = gamma_byte(rs);
            x.byte_green = gamma_byte(gs);
            x.byte_blue  = gamma_byte(bs);
          end
        endcase
      end
      pending_bytes.push_back(x);
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending_bytes.pop_front();
      if (got.byte_red !== want.byte_red)
        $display("%0t: byte_red expected %0d actual %0d", $time, want.byte_red, got.byte_red);
      if (got.byte_green !== want.byte_green)
        $display("%0t: byte_green expected %0d actual %0d", $time, want.byte_green,
                 got.byte_green);
      if (got.byte_blue !== want.byte_blue)
        $display("%0t: byte_blue expected %0d actual %0d", $time, want.byte_blue, got.byte_blue);
      if (got.status !== want.status)
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      if (got !== want) errors++;
    endfunction
  endclass

  logic        clk_i, rst_ni, start_i, busy_o, done_o, cfg_we_i;
  req_t        req_i;
  rsp_t        rsp_o;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_wdata_i;

  frame_scoreboard sb = new();
  int unsigned cycles = 0;
  int clears_left = 3;
  bit quiet_phase = 0;

  sample_accumulate_gamma_resolve dut (.*);

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(rsp_o);
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send(req_t r);
    if (!quiet_phase && $urandom_range(0, 99) < 16) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (busy_o);
    sb.note_request(r);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (sb.pending_bytes.size() != 0) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // junk in the unused upper data bits must be ignored
  task automatic cfg_write(reg_idx_e idx, int unsigned val, int w);
    logic [15:0] data;
    data = 16'(val) | (16'($urandom) << w);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    sb.write_reg(idx, data);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic req_t make_req(cmd_e c, int col, int row, int r, int g, int b);
    req_t x;
    x.cmd          = c;
    x.column       = col[7:0];
    x.row          = row[7:0];
    x.sample_red   = r[15:0];
    x.sample_green = g[15:0];
    x.sample_blue  = b[15:0];
    return x;
  endfunction

  function automatic logic [15:0] rand_sample();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 16'($urandom_range(0, 8192));
    if (p < 80) return 16'($urandom);
    case ($urandom_range(0, 3))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  function automatic req_t rand_req();
    req_t x;
    int unsigned wl, hl, p;
    wl = (sb.width_cfg < 256) ? sb.width_cfg : 256;
    hl = (sb.height_cfg < 256) ? sb.height_cfg : 256;
    p  = $urandom_range(0, 99);
    if (p < 45) x.cmd = CMD_ADD;
    else if (p < 70) x.cmd = CMD_SET;
    else x.cmd = CMD_RESOLVE;
    if (clears_left > 0 && $urandom_range(0, 499) == 0) begin
      x.cmd = CMD_CLEAR;
      clears_left--;
    end
    // keep most hits on a few pixels so resolves see accumulated sums
    if (wl > 0 && hl > 0 && $urandom_range(0, 9) < 8) begin
      x.column = 8'($urandom_range(0, (wl < 8 ? wl : 8) - 1));
      x.row    = 8'($urandom_range(0, (hl < 8 ? hl : 8) - 1));
    end else if (wl > 0 && hl > 0 && $urandom_range(0, 1)) begin
      x.column = 8'($urandom_range(0, wl - 1));
      x.row    = 8'($urandom_range(0, hl - 1));
    end else begin
      x.column = 8'($urandom);
      x.row    = 8'($urandom);
    end
    x.sample_red   = rand_sample();
    x.sample_green = rand_sample();
    x.sample_blue  = rand_sample();
    return x;
  endfunction

  int unsigned frame_w[7] = '{256, 8, 1, 0, 511, 20, 256};
  int unsigned frame_h[7] = '{256, 4, 1, 5, 300, 17, 256};
  int unsigned spp_set[7] = '{1, 4, 65535, 0, 3, 2, 1};
  int unsigned gam_set[7] = '{4096, 9011, 410, 0, 32767, 1, 2048};

  initial begin
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    req_i       = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_WIDTH;
    cfg_wdata_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, saturation edges, clear, reset-state reads
    send(make_req(CMD_RESOLVE, 7, 7, 0, 0, 0));
    send(make_req(CMD_SET, 0, 0, 4096, 4095, 1));
    send(make_req(CMD_RESOLVE, 0, 0, 0, 0, 0));
    send(make_req(CMD_SET, 255, 255, 32767, -32768, 0));
    send(make_req(CMD_RESOLVE, 255, 255, 0, 0, 0));
    send(make_req(CMD_ADD, 255, 255, -1, 32767, 1));
    send(make_req(CMD_ADD, 255, 255, -32768, -32768, -1));
    send(make_req(CMD_RESOLVE, 255, 255, 0, 0, 0));
    send(make_req(CMD_SET, 1, 0, 2048, 1024, 2));
    send(make_req(CMD_RESOLVE, 1, 0, 0, 0, 0));
    send(make_req(CMD_ADD, 1, 0, 2047, 3071, 4093));
    send(make_req(CMD_RESOLVE, 1, 0, 0, 0, 0));
    send(make_req(CMD_CLEAR, 9, 9, -1, -1, -1));
    send(make_req(CMD_RESOLVE, 0, 0, 0, 0, 0));
    send(make_req(CMD_RESOLVE, 1, 0, 0, 0, 0));
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      cfg_write(REG_WIDTH, frame_w[ph], 9);
      cfg_write(REG_HEIGHT, frame_h[ph], 9);
      cfg_write(REG_SPP, spp_set[ph], 16);
      cfg_write(REG_GAMMA, gam_set[ph], 15);
      quiet_phase = (ph == 2);
      for (int i = 0; i < 200; i++) send(rand_req());
      drain();
    end

    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_bytes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
